@@ sv/multi_turn_encoder_tracker_defines.svh @@
// Assertion macros shared by the tracker RTL.
`ifndef MULTI_TURN_ENCODER_TRACKER_DEFINES_SVH
`define MULTI_TURN_ENCODER_TRACKER_DEFINES_SVH

// The antecedent implies the consequent in the same cycle.
`define MTET_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tracker check failed");

// The antecedent implies the consequent in the next cycle.
`define MTET_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tracker check failed");

`endif

@@ sv/mtet_pkg.sv @@
`default_nettype none

package mtet_pkg;

    localparam int POS_W           = 13;
    localparam int MODE_W          = 2;
    localparam int CH_W            = 2;
    localparam int SUM_W           = 32;
    localparam int CHANNELS        = 4;
    localparam int CH_ADDR_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int COUNTS_PER_TURN = 8192;
    localparam int HALF_TURN       = COUNTS_PER_TURN / 2;
    localparam int DELTA_W         = POS_W + 2;

    localparam logic [MODE_W-1:0] MODE_UPDATE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ZERO   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [CH_W-1:0]   channel;
        logic [POS_W-1:0]  position;
    } in_beat_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] acc_angle;
        logic signed [SUM_W-1:0] acc_turns;
        logic [POS_W-1:0]        last_position;
        logic                    ignored;
    } out_beat_t;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic [SUM_W-1:0] angle;
        logic [SUM_W-1:0] turns;
    } entry_t;

    typedef struct packed {
        logic in_range;
        logic armed;
    } upd_ctrl_t;

    typedef struct packed {
        logic   write;
        logic   arm;
        logic   ignored;
        entry_t entry;
    } upd_res_t;

endpackage

`default_nettype wire

@@ sv/mtet_ram.sv @@
`default_nettype none

module mtet_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                                      aclk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic                                      re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ sv/mtet_unwrap.sv @@
`default_nettype none

module mtet_unwrap (
    input  wire mtet_pkg::in_beat_t  item,
    input  wire mtet_pkg::upd_ctrl_t ctrl,
    input  wire mtet_pkg::entry_t    stored,
    output mtet_pkg::upd_res_t       res
);

    import mtet_pkg::*;

    localparam logic signed [DELTA_W-1:0] HALF_D = DELTA_W'(HALF_TURN);
    localparam logic signed [DELTA_W-1:0] TURN_D = DELTA_W'(COUNTS_PER_TURN);

    entry_t                    cur;
    logic signed [DELTA_W-1:0] diff;
    logic signed [DELTA_W-1:0] step;
    logic                      wrap_fwd;
    logic                      wrap_bwd;
    entry_t                    advanced;

    // A channel that has never been armed reads as zero; the memory itself is never cleared.
    assign cur = ctrl.armed ? stored : '0;

    assign diff     = signed'({2'b00, item.position}) - signed'({2'b00, cur.position});
    assign wrap_fwd = diff < -HALF_D;
    assign wrap_bwd = diff > HALF_D;

    always_comb begin
        advanced          = cur;
        advanced.position = item.position;
        priority if (wrap_fwd) begin
            step           = diff + TURN_D;
            advanced.turns = cur.turns + SUM_W'(1);
        end else if (wrap_bwd) begin
            step           = diff - TURN_D;
            advanced.turns = cur.turns - SUM_W'(1);
        end else begin
            step = diff;
        end
        advanced.angle = cur.angle + {{(SUM_W - DELTA_W){step[DELTA_W-1]}}, step};
    end

    always_comb begin
        res.write   = 1'b0;
        res.arm     = 1'b0;
        res.ignored = 1'b0;
        res.entry   = cur;
        if (!ctrl.in_range) begin
            res.entry   = '0;
            res.ignored = (item.mode == MODE_UPDATE);
        end else if (item.mode == MODE_ZERO) begin
            res.write          = 1'b1;
            res.arm            = 1'b1;
            res.entry.position = item.position;
            res.entry.angle    = '0;
            res.entry.turns    = '0;
        end else if (item.mode == MODE_UPDATE) begin
            if (ctrl.armed) begin
                res.write = 1'b1;
                res.entry = advanced;
            end else begin
                res.ignored = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/multi_turn_encoder_tracker.sv @@
// A result is formed in ST_EXEC from the registered item and memory read, then registered once the output is free.
// s_ready is high only in ST_IDLE, so a new item is not taken until the previous one has finished.
// A finished result waits in an output register while the next item is taken.
// Reset (aresetn low, synchronous) clears the arm flags, the control state and the output valid.
// A channel that is not armed reads as zero, so the memory needs no clearing pass after reset.
`default_nettype none
`include "multi_turn_encoder_tracker_defines.svh"

module multi_turn_encoder_tracker (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire mtet_pkg::in_beat_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output mtet_pkg::out_beat_t      m_data
);

    import mtet_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    in_beat_t               item_reg;
    logic [CHANNELS-1:0]    armed_reg;
    logic [CHANNELS-1:0]    armed_next;
    logic                   m_valid_reg;
    logic                   m_valid_next;
    out_beat_t              out_reg;

    logic                   accept;
    logic                   out_free;
    logic                   finish;
    logic                   ram_we;
    logic [$bits(entry_t)-1:0] ram_rdata;
    entry_t                 stored;
    upd_ctrl_t              ctrl;
    upd_res_t               res;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign finish   = (state_reg == ST_EXEC) && out_free;
    assign ram_we   = finish && res.write;
    assign stored   = entry_t'(ram_rdata);

    mtet_ram #(
        .WIDTH($bits(entry_t)),
        .DEPTH(CHANNELS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (CH_ADDR_W'(item_reg.channel)),
        .wdata (res.entry),
        .re    (accept),
        .raddr (CH_ADDR_W'(s_data.channel)),
        .rdata (ram_rdata)
    );

    always_comb begin
        ctrl.in_range = (int'(item_reg.channel) < CHANNELS);
        ctrl.armed    = 1'b0;
        for (int i = 0; i < CHANNELS; i++) begin
            if (int'(item_reg.channel) == i) begin
                ctrl.armed = armed_reg[i];
            end
        end
    end

    mtet_unwrap u_unwrap (
        .item   (item_reg),
        .ctrl   (ctrl),
        .stored (stored),
        .res    (res)
    );

    always_comb begin
        state_next   = state_reg;
        armed_next   = armed_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                    for (int i = 0; i < CHANNELS; i++) begin
                        if (res.arm && int'(item_reg.channel) == i) begin
                            armed_next[i] = 1'b1;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            armed_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            armed_reg   <= armed_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_data;
        end
        if (finish) begin
            out_reg.acc_angle     <= res.entry.angle;
            out_reg.acc_turns     <= res.entry.turns;
            out_reg.last_position <= res.entry.position;
            out_reg.ignored       <= res.ignored;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    `MTET_ASSERT_IMPLY(a_no_read_on_write, ram_we, !accept)
    `MTET_ASSERT_IMPLY(a_write_in_range, ram_we, ctrl.in_range)
    `MTET_ASSERT_NEXT(a_accept_to_exec, accept, state_reg == ST_EXEC)
    `MTET_ASSERT_NEXT(a_finish_gives_result, finish, m_valid_reg)
    `MTET_ASSERT_NEXT(a_arm_only_on_zero, !(finish && res.arm), armed_reg == $past(armed_reg))

endmodule

`default_nettype wire

@@ tb/sv/multi_turn_encoder_tracker_tb.sv @@
`timescale 1ns / 1ps

module multi_turn_encoder_tracker_tb;

    import mtet_pkg::*;

    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    localparam int RANDOM_ITEMS = 930;
    localparam int CALM_ITEMS   = 150;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_AT     = 600;
    localparam int STALL_LIMIT  = 1000;
    localparam int SETTLE       = 8;
    localparam int PRINT_LIMIT  = 100;

    typedef struct {
        in_beat_t  beat;
        bit        fixed;
        out_beat_t readout;
    } plan_row_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_beat_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_data;

    logic [POS_W-1:0] enc_pos   [CHANNELS];
    logic [SUM_W-1:0] enc_angle [CHANNELS];
    logic [SUM_W-1:0] enc_turns [CHANNELS];
    bit               enc_armed [CHANNELS];

    out_beat_t expected_readouts[$];
    int        accepted_items = 0;
    int        quiet_cycles   = 0;
    int        mismatch_count = 0;

    multi_turn_encoder_tracker dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #10 aclk = ~aclk;

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        for (int i = 0; i < CHANNELS; i++) begin
            enc_pos[i]   = '0;
            enc_angle[i] = '0;
            enc_turns[i] = '0;
            enc_armed[i] = 1'b0;
        end
    end

    function automatic out_beat_t unwrap_reading(input in_beat_t b);
        out_beat_t r;
        int ch;
        int step;
        r = '0;
        ch = int'(b.channel);
        if (ch >= CHANNELS) begin
            r.ignored = (b.mode == MODE_UPDATE);
            return r;
        end
        if (b.mode == MODE_ZERO) begin
            enc_pos[ch]   = b.position;
            enc_angle[ch] = '0;
            enc_turns[ch] = '0;
            enc_armed[ch] = 1'b1;
        end else if (b.mode == MODE_UPDATE) begin
            if (!enc_armed[ch]) begin
                r.ignored = 1'b1;
            end else begin
                step = int'(b.position) - int'(enc_pos[ch]);
                if (step < -HALF_TURN) begin
                    enc_turns[ch] = enc_turns[ch] + 1;
                    step = step + COUNTS_PER_TURN;
                end else if (step > HALF_TURN) begin
                    enc_turns[ch] = enc_turns[ch] - 1;
                    step = step - COUNTS_PER_TURN;
                end
                enc_angle[ch] = enc_angle[ch] + step;
                enc_pos[ch] = b.position;
            end
        end
        r.acc_angle     = enc_angle[ch];
        r.acc_turns     = enc_turns[ch];
        r.last_position = enc_pos[ch];
        return r;
    endfunction

    function automatic in_beat_t next_random_beat();
        in_beat_t b;
        int pick;
        int offset;
        int sign;
        b.channel  = CH_W'($urandom_range(CHANNELS - 1));
        b.position = POS_W'($urandom);
        pick = $urandom_range(99);
        sign = $urandom_range(1) ? 1 : -1;
        if (pick < 72) begin
            b.mode = MODE_UPDATE;
            case ($urandom_range(3))
                0: offset = 0;
                1: offset = sign * (HALF_TURN - 1 + int'($urandom_range(2)));
                2: offset = int'($urandom_range(200)) - 100;
                default: offset = sign * (3000 + int'($urandom_range(HALF_TURN - 3000)));
            endcase
            if (offset != 0) begin
                b.position = POS_W'(int'(enc_pos[b.channel]) + offset);
            end
        end else if (pick < 82) begin
            b.mode = MODE_ZERO;
        end else if (pick < 94) begin
            b.mode = MODE_READ;
        end else begin
            b.mode = MODE_SPARE;
        end
        return b;
    endfunction

    function automatic plan_row_t plan_row(input logic [MODE_W-1:0] mode,
                                           input logic [CH_W-1:0] ch,
                                           input logic [POS_W-1:0] pos,
                                           input bit fixed = 1'b0,
                                           input logic [SUM_W-1:0] angle = '0,
                                           input logic [SUM_W-1:0] turns = '0,
                                           input logic [POS_W-1:0] last = '0,
                                           input bit ignored = 1'b0);
        plan_row_t r;
        r.beat.mode             = mode;
        r.beat.channel          = ch;
        r.beat.position         = pos;
        r.fixed                 = fixed;
        r.readout.acc_angle     = angle;
        r.readout.acc_turns     = turns;
        r.readout.last_position = last;
        r.readout.ignored       = ignored;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("MISMATCH at %0t ns: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    task automatic check_readout(input out_beat_t got);
        out_beat_t want;
        if (expected_readouts.size() == 0) begin
            report_mismatch($sformatf("readout %h with nothing expected", got));
            return;
        end
        want = expected_readouts.pop_front();
        if (got.acc_angle !== want.acc_angle) begin
            report_mismatch($sformatf("acc_angle %0d, expected %0d",
                                      got.acc_angle, want.acc_angle));
        end
        if (got.acc_turns !== want.acc_turns) begin
            report_mismatch($sformatf("acc_turns %0d, expected %0d",
                                      got.acc_turns, want.acc_turns));
        end
        if (got.last_position !== want.last_position) begin
            report_mismatch($sformatf("last_position %0d, expected %0d",
                                      got.last_position, want.last_position));
        end
        if (got.ignored !== want.ignored) begin
            report_mismatch($sformatf("ignored %b, expected %b", got.ignored, want.ignored));
        end
    endtask

    task automatic offer_beat(input in_beat_t b, input bit fixed, input out_beat_t typed);
        out_beat_t predicted;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge aclk); while (!s_ready);
        predicted = unwrap_reading(b);
        expected_readouts.push_back(fixed ? typed : predicted);
    endtask

    task automatic idle_sender(input int cycles);
        @(negedge aclk);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    task automatic drain_readouts();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_readouts.size() != 0) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                accepted_items++;
            end
            if (m_valid && m_ready) begin
                check_readout(m_data);
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin : result_receiver
        bit hold_done;
        hold_done = 1'b0;
        while (!aresetn) @(negedge aclk);
        forever begin
            @(negedge aclk);
            if (!hold_done && accepted_items >= HOLD_AT) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else if (accepted_items < RANDOM_ITEMS - CALM_ITEMS
                         && $urandom_range(5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(10)) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : item_sender
        plan_row_t plan[$];
        int done;
        plan.push_back(plan_row(MODE_READ,   2'd0, 13'd0,    1'b1, 0, 0, 13'd0, 1'b0));
        plan.push_back(plan_row(MODE_SPARE,  2'd1, 13'd8191, 1'b1, 0, 0, 13'd0, 1'b0));
        plan.push_back(plan_row(MODE_UPDATE, 2'd2, 13'd8191, 1'b1, 0, 0, 13'd0, 1'b1));
        plan.push_back(plan_row(MODE_UPDATE, 2'd3, 13'd0,    1'b1, 0, 0, 13'd0, 1'b1));
        plan.push_back(plan_row(MODE_ZERO,   2'd0, 13'd0,    1'b1, 0, 0, 13'd0, 1'b0));
        plan.push_back(plan_row(MODE_UPDATE, 2'd0, 13'd4096));
        plan.push_back(plan_row(MODE_UPDATE, 2'd0, 13'd0));
        plan.push_back(plan_row(MODE_UPDATE, 2'd0, 13'd4097));
        plan.push_back(plan_row(MODE_UPDATE, 2'd0, 13'd0));
        plan.push_back(plan_row(MODE_UPDATE, 2'd0, 13'd8191));
        plan.push_back(plan_row(MODE_UPDATE, 2'd0, 13'd0));
        plan.push_back(plan_row(MODE_ZERO,   2'd3, 13'd8191, 1'b1, 0, 0, 13'd8191, 1'b0));
        plan.push_back(plan_row(MODE_UPDATE, 2'd3, 13'd0));
        plan.push_back(plan_row(MODE_UPDATE, 2'd3, 13'd8191));
        plan.push_back(plan_row(MODE_READ,   2'd3, 13'd5555));
        plan.push_back(plan_row(MODE_SPARE,  2'd3, 13'd1234));
        plan.push_back(plan_row(MODE_ZERO,   2'd1, 13'h1555, 1'b1, 0, 0, 13'h1555, 1'b0));
        plan.push_back(plan_row(MODE_UPDATE, 2'd1, 13'h0aaa));
        plan.push_back(plan_row(MODE_ZERO,   2'd2, 13'h0aaa, 1'b1, 0, 0, 13'h0aaa, 1'b0));
        plan.push_back(plan_row(MODE_UPDATE, 2'd2, 13'h1555));
        plan.push_back(plan_row(MODE_UPDATE, 2'd2, 13'h0554));
        plan.push_back(plan_row(MODE_ZERO,   2'd0, 13'd4096, 1'b1, 0, 0, 13'd4096, 1'b0));
        plan.push_back(plan_row(MODE_UPDATE, 2'd0, 13'd4096));

        while (!aresetn) @(posedge aclk);
        foreach (plan[i]) begin
            if ($urandom_range(3) == 0) begin
                idle_sender($urandom_range(1, 11));
            end
            offer_beat(plan[i].beat, plan[i].fixed, plan[i].readout);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            done = n + plan.size();
            if (n == DRAIN_AT) begin
                drain_readouts();
            end else if (n < RANDOM_ITEMS - CALM_ITEMS
                         && (done < HOLD_AT - 20 || done > HOLD_AT + 60)
                         && $urandom_range(3) == 0) begin
                idle_sender($urandom_range(1, 11));
            end
            offer_beat(next_random_beat(), 1'b0, '0);
        end

        drain_readouts();
        repeat (SETTLE) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
